### hw/rtl/bumc_pkg.sv
// Package for the block use map checker: configuration register codes,
// the configuration bundle type and fixed field widths.
// No dependencies.
package bumc_pkg;

    // Fixed widths of the item fields
    localparam int BLK_W     = 16;
    localparam int MAP_BITS  = 16;  // blocks per bitmap word
    localparam int BIT_IDX_W = 4;   // bit position inside a word
    localparam int CNT_W     = 16;
    localparam int MARK_W    = 17;
    localparam int MISS_W    = 17;
    localparam int NUM_WATCH = 6;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INODE_AREA = 3'd0,
        CFG_VOLUME     = 3'd1,
        CFG_WATCH_A    = 3'd2,
        CFG_WATCH_B    = 3'd3,
        CFG_WATCH_C    = 3'd4,
        CFG_WATCH_D    = 3'd5,
        CFG_WATCH_E    = 3'd6,
        CFG_WATCH_F    = 3'd7
    } t_cfg_idx;

    // Current register contents, handed to the core
    typedef struct packed {
        logic [BLK_W-1:0]                inode_area;
        logic [BLK_W-1:0]                volume;
        logic [NUM_WATCH-1:0][BLK_W-1:0] watch;
    } t_cfg;

endpackage

### hw/rtl/bumc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bumc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bumc_cfg.sv
// Configuration register file of the block use map checker.
// Depends on bumc_pkg for the register codes and the t_cfg bundle.
module bumc_cfg
    import bumc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BLK_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx)) inside
                CFG_INODE_AREA: n_cfg.inode_area = i_cfg_data;
                CFG_VOLUME:     n_cfg.volume     = i_cfg_data;
                CFG_WATCH_A, CFG_WATCH_B, CFG_WATCH_C,
                CFG_WATCH_D, CFG_WATCH_E, CFG_WATCH_F: begin
                    n_cfg.watch[i_cfg_idx - CFG_IDX_W'(CFG_WATCH_A)] = i_cfg_data;
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/block_use_map_checker_core.sv
// Block use map checker: bitmap duplicate detection with saturating counters.
// Flow: the bitmap word is read when an item is accepted; its result is registered
// at write-back, held off by an output stall; one item is in flight at a time.
// Reset: counters and control registers clear; the bitmap is then swept to zero,
// one word a cycle, with input stalled (config still taken).
// Depends on bumc_pkg, bumc_cfg and bumc_ram.
module block_use_map_checker_core
    import bumc_pkg::*;
#(
    parameter int MAP_WORDS = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [BLK_W-1:0]         i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [BLK_W-1:0]         i_block_number,
    input  logic                     i_claimed_by_inode,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_out_of_range,
    output logic                     o_duplicate,
    output logic                     o_watched_hit,
    output logic [CNT_W-1:0]         o_used_total,
    output logic [CNT_W-1:0]         o_duplicate_total,
    output logic signed [MISS_W-1:0] o_missing_blocks
);

    localparam int ADDR_W = $clog2(MAP_WORDS);
    localparam int WIDX_W = BLK_W - BIT_IDX_W;   // word index width of a block number
    localparam int DIFF_W = MARK_W + 2;          // room for missing before clamping

    t_cfg cfg;

    bumc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Control state
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_busy;
    logic              r_out_valid;

    // Item held between read and write-back
    logic [BLK_W-1:0]  r_blk;
    logic              r_by_inode;
    logic              r_oor;

    // Counters
    logic [CNT_W-1:0]  r_used_count;
    logic [CNT_W-1:0]  r_dup_count;
    logic [MARK_W-1:0] r_marked_count;

    // Result register
    logic                     r_out_oor;
    logic                     r_out_dup;
    logic                     r_out_hit;
    logic signed [MISS_W-1:0] r_out_missing;

    logic              in_accept;
    logic              wb_done;
    logic              oor_now;
    logic [MAP_BITS-1:0] rd_data;
    logic [MAP_BITS-1:0] bit_mask;
    logic              bit_set;
    logic              dup;
    logic              mark;
    logic              hit;
    logic [MARK_W-1:0] n_marked_count;
    logic [CNT_W-1:0]  n_used_count;
    logic [CNT_W-1:0]  n_dup_count;
    logic signed [DIFF_W-1:0] miss_diff;
    logic signed [MISS_W-1:0] n_missing;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [MAP_BITS-1:0] ram_wdata;

    // Handshake: one item in flight; write-back waits for a free result register
    assign o_in_stall = r_clearing || r_busy;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign wb_done    = r_busy && (!r_out_valid || !i_out_stall);

    // Range check at accept; user must keep registers stable while items in flight
    assign oor_now = ({1'b0, i_block_number} < ({1'b0, cfg.inode_area} + (BLK_W+1)'(2)))
                  || (i_block_number >= cfg.volume)
                  || ({1'b0, i_block_number[BLK_W-1:BIT_IDX_W]} >= (WIDX_W+1)'(MAP_WORDS));

    // Bitmap test
    assign bit_mask = MAP_BITS'(1) << r_blk[BIT_IDX_W-1:0];
    assign bit_set  = (rd_data & bit_mask) != '0;
    assign dup      = !r_oor && bit_set;
    assign mark     = !r_oor && !bit_set;

    // Watch list compare
    always_comb begin
        hit = 1'b0;
        for (int w = 0; w < NUM_WATCH; w++) begin
            if (cfg.watch[w] != '0 && cfg.watch[w] == r_blk) begin
                hit = 1'b1;
            end
        end
        hit = hit && !r_oor;
    end

    // Saturating counter updates
    always_comb begin
        n_used_count   = r_used_count;
        n_dup_count    = r_dup_count;
        n_marked_count = r_marked_count;
        if (r_by_inode && r_used_count != '1) begin
            n_used_count = r_used_count + CNT_W'(1);
        end
        if (dup && r_dup_count != '1) begin
            n_dup_count = r_dup_count + CNT_W'(1);
        end
        if (mark && r_marked_count != '1) begin
            n_marked_count = r_marked_count + MARK_W'(1);
        end
    end

    // Missing blocks, clamped to the 17-bit signed range
    always_comb begin
        miss_diff = $signed(DIFF_W'(cfg.volume)) - $signed(DIFF_W'(cfg.inode_area))
                  - $signed(DIFF_W'(2)) - $signed(DIFF_W'(n_marked_count));
        if (miss_diff < -$signed(DIFF_W'(65536))) begin
            n_missing = {1'b1, {(MISS_W-1){1'b0}}};
        end else if (miss_diff > $signed(DIFF_W'(65535))) begin
            n_missing = {1'b0, {(MISS_W-1){1'b1}}};
        end else begin
            n_missing = miss_diff[MISS_W-1:0];
        end
    end

    // Bitmap write mux: clearing sweep or write-back of a newly marked bit
    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = wb_done && mark;
            ram_waddr = r_blk[BIT_IDX_W +: ADDR_W];
            ram_wdata = rd_data | bit_mask;
        end
    end

    bumc_ram #(
        .WIDTH (MAP_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (i_block_number[BIT_IDX_W +: ADDR_W]),
        .o_rdata (rd_data)
    );

    // Control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing     <= 1'b1;
            r_clr_addr     <= '0;
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_used_count   <= '0;
            r_dup_count    <= '0;
            r_marked_count <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(MAP_WORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (wb_done) begin
                r_busy <= 1'b0;
            end
            if (wb_done) begin
                r_out_valid    <= 1'b1;
                r_used_count   <= n_used_count;
                r_dup_count    <= n_dup_count;
                r_marked_count <= n_marked_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_blk      <= i_block_number;
            r_by_inode <= i_claimed_by_inode;
            r_oor      <= oor_now;
        end
        if (wb_done) begin
            r_out_oor     <= r_oor;
            r_out_dup     <= dup;
            r_out_hit     <= hit;
            r_out_missing <= n_missing;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_of_range    = r_out_oor;
    assign o_duplicate       = r_out_dup;
    assign o_watched_hit     = r_out_hit;
    assign o_used_total      = r_used_count;
    assign o_duplicate_total = r_dup_count;
    assign o_missing_blocks  = r_out_missing;

    // No item is in flight during the clearing sweep
    a_no_busy_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_busy)
        else $error("item in flight during bitmap clear");

    // A write-back only ever sets a bit of an in-range block that was clear
    a_wb_marks_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !r_clearing) |-> (wb_done && !r_oor && !bit_set))
        else $error("bitmap write-back of a marked or out-of-range block");

    // Counters never move backward outside reset
    a_counters_monotonic: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |->
            (r_used_count >= $past(r_used_count) && r_dup_count >= $past(r_dup_count)
             && r_marked_count >= $past(r_marked_count)))
        else $error("saturating counter decreased");

    // A result flagged out of range is never also a duplicate or a watch hit
    a_oor_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oor) |-> (!r_out_dup && !r_out_hit))
        else $error("out-of-range result with duplicate or watch flag");

endmodule
